FILE: sv/ctsc_pkg.sv
// Shared types, codes and byte functions for the counter-mode SPN cipher.
package ctsc_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_ENCRYPT = 2'd2;

    localparam logic CFG_KEY   = 1'b0;
    localparam logic CFG_ORDER = 1'b1;

    localparam logic [7:0]  RCON_A      = 8'h80;
    localparam logic [7:0]  RCON_B      = 8'h30;
    localparam logic [23:0] ORDER_RESET = 24'hFAC688;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sbox_index;
        logic [7:0]  sbox_value;
        logic [7:0]  start_high;
        logic [15:0] plain_block;
    } t_in_req;

    typedef struct packed {
        logic [15:0] cipher_block;
        logic [15:0] counter_used;
    } t_out_req;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_sbox_wr;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
    } t_sbox_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    function automatic logic [7:0] nib_swap(input logic [7:0] v);
        return {v[3:0], v[7:4]};
    endfunction

    function automatic logic [7:0] permute_byte(input logic [7:0] v, input logic [23:0] order);
        logic [7:0] res;
        logic [2:0] src;
        res = 8'd0;
        for (int i = 0; i < 8; i++) begin
            src = order[3*i +: 3];
            res[3'(7 - i)] = v[3'd7 - src];
        end
        return res;
    endfunction

endpackage

FILE: sv/ctsc_sbox.sv
// S-box RAM, 256 x 8, registered read, per-entry valid bits for reset-to-zero.
module ctsc_sbox (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctsc_pkg::t_sbox_wr  i_wr,
    input  ctsc_pkg::t_sbox_rd  i_rd,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [256];
    logic [255:0] r_vld;
    logic [7:0] r_q;
    logic       r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_q_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : 8'd0;

endmodule

FILE: sv/ctr_tiny_spn_cipher.sv
// Top level: counter-mode encryption over a 16-bit SPN cipher with a loadable S-box.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in      | request   | i_in_valid / o_in_stall | i_in_data  (t_in_req)
//  out     | result    | o_out_valid / i_out_stall | o_out_data (t_out_req)
//  cfg     | write     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Load, restart and unused requests complete on acceptance. An encrypt request passes
// through the accept cycle, eight chained S-box reads (two for key expansion, two per
// round) and the DONE state, which registers the result. Synchronous active-low reset
// clears the counter, key, output valid flag and all S-box valid bits and reloads the
// reset bit order; no clearing pass is needed. A stalled result holds the engine in
// its final state, while a new request is taken as soon as the engine is idle.
module ctr_tiny_spn_cipher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ctsc_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ctsc_pkg::t_out_req o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    ctsc_pkg::t_state r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_key;
    logic [23:0] r_order;
    logic [15:0] r_ctr, n_ctr;
    logic [15:0] r_ctr_used;
    logic [15:0] r_plain;
    logic [15:0] r_sk1, n_sk1;
    logic [15:0] r_sk2, n_sk2;
    logic [15:0] r_m, n_m;
    logic [7:0]  r_hi, n_hi;
    logic        r_out_valid;
    ctsc_pkg::t_out_req r_out_data;

    ctsc_pkg::t_sbox_wr sbox_wr;
    ctsc_pkg::t_sbox_rd sbox_rd;
    logic [7:0] sbox_q;
    logic [7:0] q_perm;
    logic       in_acc;
    logic       out_free;
    logic       load_out;
    logic [7:0] a2, a3, a4, a5;
    logic [15:0] m_next;

    assign o_in_stall  = (r_state != ctsc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    ctsc_sbox u_sbox (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (sbox_wr),
        .i_rd      (sbox_rd),
        .o_rd_data (sbox_q)
    );

    assign q_perm = ctsc_pkg::permute_byte(sbox_q, r_order);
    assign a2     = r_key[15:8] ^ ctsc_pkg::RCON_A ^ sbox_q;
    assign a3     = a2 ^ r_key[7:0];
    assign a4     = r_sk1[15:8] ^ ctsc_pkg::RCON_B ^ sbox_q;
    assign a5     = a4 ^ r_sk1[7:0];

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ctsc_pkg::ST_IDLE: begin
                n_step = 3'd0;
                if (in_acc && i_in_data.op == ctsc_pkg::OP_ENCRYPT) begin
                    n_state = ctsc_pkg::ST_RUN;
                end
            end
            ctsc_pkg::ST_RUN: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = ctsc_pkg::ST_DONE;
                end
            end
            ctsc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ctsc_pkg::ST_IDLE;
                end
            end
            default: n_state = ctsc_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        sbox_wr.en   = in_acc && i_in_data.op == ctsc_pkg::OP_LOAD;
        sbox_wr.addr = i_in_data.sbox_index;
        sbox_wr.data = i_in_data.sbox_value;
        sbox_rd.en   = (r_state == ctsc_pkg::ST_RUN);
        sbox_rd.addr = 8'd0;
        load_out     = (r_state == ctsc_pkg::ST_DONE) && out_free;
        n_ctr        = r_ctr;
        n_sk1        = r_sk1;
        n_sk2        = r_sk2;
        n_m          = r_m;
        n_hi         = r_hi;
        m_next       = {r_hi, q_perm};
        if (in_acc) begin
            case (i_in_data.op)
                ctsc_pkg::OP_RESTART: n_ctr = {i_in_data.start_high, 8'd0};
                ctsc_pkg::OP_ENCRYPT: n_ctr = r_ctr + 16'd1;
                default:              n_ctr = r_ctr;
            endcase
        end
        if (r_state == ctsc_pkg::ST_RUN) begin
            case (r_step)
                3'd0: sbox_rd.addr = ctsc_pkg::nib_swap(r_key[7:0]);
                3'd1: begin
                    n_sk1        = {a2, a3};
                    sbox_rd.addr = ctsc_pkg::nib_swap(a3);
                end
                3'd2: begin
                    n_sk2        = {a4, a5};
                    n_m          = r_ctr_used ^ r_key;
                    sbox_rd.addr = n_m[15:8];
                end
                3'd4: begin
                    n_m          = m_next ^ r_sk1;
                    sbox_rd.addr = n_m[15:8];
                end
                3'd6: begin
                    n_m          = m_next ^ r_sk2;
                    sbox_rd.addr = n_m[15:8];
                end
                default: begin
                    n_hi         = q_perm;
                    sbox_rd.addr = r_m[7:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctsc_pkg::ST_IDLE;
            r_step      <= 3'd0;
            r_ctr       <= 16'd0;
            r_key       <= 16'd0;
            r_order     <= ctsc_pkg::ORDER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ctr   <= n_ctr;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ctsc_pkg::CFG_KEY:   r_key   <= i_cfg_data[15:0];
                    ctsc_pkg::CFG_ORDER: r_order <= i_cfg_data;
                    default:             r_key   <= r_key;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sk1 <= n_sk1;
        r_sk2 <= n_sk2;
        r_m   <= n_m;
        r_hi  <= n_hi;
        if (in_acc && i_in_data.op == ctsc_pkg::OP_ENCRYPT) begin
            r_ctr_used <= r_ctr;
            r_plain    <= i_in_data.plain_block;
        end
        if (load_out) begin
            r_out_data.cipher_block <= r_plain ^ m_next;
            r_out_data.counter_used <= r_ctr_used;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_enc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.op == ctsc_pkg::OP_ENCRYPT
        |=> r_state == ctsc_pkg::ST_RUN && r_step == 3'd0 && r_ctr == $past(r_ctr) + 16'd1)
        else $error("encrypt request did not start the engine and advance the counter");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.op == ctsc_pkg::OP_RESTART
        |=> r_ctr == {$past(i_in_data.start_high), 8'd0})
        else $error("restart did not load the counter");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctsc_pkg::ST_DONE && out_free
        |=> o_out_valid && o_out_data.counter_used == $past(r_ctr_used))
        else $error("finished block did not reach the output register");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sbox_wr.en |-> !sbox_rd.en)
        else $error("S-box written while the engine reads it");
`endif

endmodule

FILE: tb/tb_ctr_tiny_spn_cipher.sv
// Self-checking testbench for the counter-mode SPN cipher: directed and random requests, predicted results.
module tb_ctr_tiny_spn_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE      = 16;
    localparam int         PHASE_ITEMS = 210;
    localparam int         WRAP_BLOCKS = 258;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 500000;

    class cipher_predictor;
        logic [7:0]         sbox[256];
        logic [15:0]        counter;
        logic [15:0]        key;
        logic [23:0]        order;
        ctsc_pkg::t_out_req expected_blocks[$];
        int                 n_errors;

        function new();
            foreach (sbox[i]) sbox[i] = 8'h00;
            counter  = 16'h0000;
            key      = 16'h0000;
            order    = ctsc_pkg::ORDER_RESET;
            n_errors = 0;
        endfunction

        function void set_reg(logic idx, logic [23:0] data);
            if (idx == ctsc_pkg::CFG_KEY) key = data[15:0];
            else order = data;
        endfunction

        function logic [7:0] flip_nibbles(logic [7:0] v);
            return {v[3:0], v[7:4]};
        endfunction

        function logic [7:0] shuffle_bits(logic [7:0] v);
            logic [7:0] res;
            int         src;
            res = 8'h00;
            for (int i = 0; i < 8; i++) begin
                src = int'(order[3*i +: 3]);
                res[7-i] = v[7-src];
            end
            return res;
        endfunction

        function logic [15:0] keystream(logic [15:0] ctr);
            logic [7:0]  a0, a1, a2, a3, a4, a5;
            logic [15:0] subkey[3];
            logic [15:0] m;
            a0 = key[15:8];
            a1 = key[7:0];
            a2 = a0 ^ ctsc_pkg::RCON_A ^ sbox[flip_nibbles(a1)];
            a3 = a2 ^ a1;
            a4 = a2 ^ ctsc_pkg::RCON_B ^ sbox[flip_nibbles(a3)];
            a5 = a4 ^ a3;
            subkey[0] = {a0, a1};
            subkey[1] = {a2, a3};
            subkey[2] = {a4, a5};
            m = ctr;
            for (int r = 0; r < 3; r++) begin
                m = m ^ subkey[r];
                m = {shuffle_bits(sbox[m[15:8]]), shuffle_bits(sbox[m[7:0]])};
            end
            return m;
        endfunction

        function void note_request(ctsc_pkg::t_in_req r);
            ctsc_pkg::t_out_req blk;
            case (r.op)
                ctsc_pkg::OP_LOAD: begin
                    sbox[r.sbox_index] = r.sbox_value;
                end
                ctsc_pkg::OP_RESTART: begin
                    counter = {r.start_high, 8'h00};
                end
                ctsc_pkg::OP_ENCRYPT: begin
                    blk.cipher_block = r.plain_block ^ keystream(counter);
                    blk.counter_used = counter;
                    expected_blocks.push_back(blk);
                    counter = counter + 16'd1;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_block(ctsc_pkg::t_out_req got);
            ctsc_pkg::t_out_req want;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result cipher=%h counter=%h",
                         $time, got.cipher_block, got.counter_used);
                n_errors++;
                return;
            end
            want = expected_blocks.pop_front();
            if (got.cipher_block !== want.cipher_block) begin
                $display("%0t: cipher_block mismatch expected=%h actual=%h",
                         $time, want.cipher_block, got.cipher_block);
                n_errors++;
            end
            if (got.counter_used !== want.counter_used) begin
                $display("%0t: counter_used mismatch expected=%h actual=%h",
                         $time, want.counter_used, got.counter_used);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    ctsc_pkg::t_in_req  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ctsc_pkg::t_out_req o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = ctsc_pkg::CFG_KEY;
    logic [23:0]        i_cfg_data  = 24'h000000;

    logic        rx_hold     = 1'b0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          cycle_count = 0;

    cipher_predictor sb = new();

    ctr_tiny_spn_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_block(o_out_data);
        end
        i_out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer(ctsc_pkg::t_in_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic ctsc_pkg::t_in_req make_req(logic [1:0] op);
        ctsc_pkg::t_in_req r;
        r.op          = op;
        r.sbox_index  = 8'($urandom);
        r.sbox_value  = 8'($urandom);
        r.start_high  = 8'($urandom);
        r.plain_block = 16'($urandom);
        return r;
    endfunction

    task automatic run_random(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 30)      offer(make_req(ctsc_pkg::OP_LOAD));
            else if (pick < 88) offer(make_req(ctsc_pkg::OP_ENCRYPT));
            else if (pick < 96) offer(make_req(ctsc_pkg::OP_RESTART));
            else                offer(make_req(OP_UNUSED));
        end
    endtask

    initial begin
        int                 blocks;
        ctsc_pkg::t_in_req  r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'h0000});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        offer('{ctsc_pkg::OP_LOAD,    8'h00, 8'hFF, 8'h00, 16'h0000});
        offer('{ctsc_pkg::OP_LOAD,    8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        offer('{ctsc_pkg::OP_LOAD,    8'h80, 8'h5A, 8'h00, 16'h0000});
        offer('{ctsc_pkg::OP_LOAD,    8'h08, 8'hC3, 8'h00, 16'h0000});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'h1234});
        offer('{ctsc_pkg::OP_RESTART, 8'h00, 8'h00, 8'hFF, 16'h0000});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'h0000});
        offer('{OP_UNUSED,            8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'hAAAA});
        offer('{ctsc_pkg::OP_RESTART, 8'hFF, 8'hFF, 8'h00, 16'hFFFF});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        offer('{ctsc_pkg::OP_LOAD,    8'h01, 8'h01, 8'hFF, 16'hFFFF});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'h5555});
        offer('{OP_UNUSED,            8'h00, 8'h00, 8'h00, 16'h0000});
        offer('{ctsc_pkg::OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 16'h8001});
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    write_reg(ctsc_pkg::CFG_KEY, 24'hFF0000);
                    write_reg(ctsc_pkg::CFG_ORDER, ctsc_pkg::ORDER_RESET);
                end
                1: begin
                    idle_pct = 81; stall_pct = 0;
                    write_reg(ctsc_pkg::CFG_KEY, 24'h00FFFF);
                    write_reg(ctsc_pkg::CFG_ORDER, 24'h000000);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 81;
                    write_reg(ctsc_pkg::CFG_KEY, 24'($urandom));
                    write_reg(ctsc_pkg::CFG_ORDER, 24'hFFFFFF);
                end
                3: begin
                    idle_pct = 9;  stall_pct = 9;
                    write_reg(ctsc_pkg::CFG_KEY, 24'($urandom));
                    write_reg(ctsc_pkg::CFG_ORDER, 24'($urandom));
                end
                default: begin
                    idle_pct = 0;  stall_pct = 0;
                    write_reg(ctsc_pkg::CFG_KEY, 24'($urandom));
                    write_reg(ctsc_pkg::CFG_ORDER, 24'($urandom));
                    fork
                        begin
                            rx_hold <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge i_clk);
                            rx_hold <= 1'b0;
                        end
                    join_none
                end
            endcase

            if (ph == 0) begin
                r = make_req(ctsc_pkg::OP_RESTART);
                r.start_high = 8'hFF;
                offer(r);
                blocks = 0;
                while (blocks < WRAP_BLOCKS) begin
                    if ($urandom_range(99) < 20) begin
                        offer(make_req(ctsc_pkg::OP_LOAD));
                    end else begin
                        offer(make_req(ctsc_pkg::OP_ENCRYPT));
                        blocks++;
                    end
                end
            end
            run_random(PHASE_ITEMS);
            settle();
        end

        if (sb.n_errors == 0 && sb.expected_blocks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
